>>> rtl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
package spq_pkg;

  // Default number of record slots.
  localparam int DEPTH_DEF = 16;

  // Field widths of one record.
  localparam int CODE_W = 16;
  localparam int PRI_W  = 8;
  localparam int PAY_W  = 64;
  localparam int OCC_W  = 5;

  // Operation carried by each input item.
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  // Status reported with each result item.
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Controller states: result register empty or holding an item.
  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_HOLD = 1'b1
  } ctl_state_t;

  // Per-slot update select in the record row.
  typedef enum logic [1:0] {
    SEL_HOLD = 2'd0,
    SEL_NEW  = 2'd1,
    SEL_PREV = 2'd2,
    SEL_NEXT = 2'd3
  } sel_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic exec;
    op_t  op;
  } cmd_t;

endpackage

>>> rtl/spq_ctrl.sv
// Handshake controller for the stable priority queue.
module spq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  spq_pkg::op_t        in_op,
  output logic                out_tvalid,
  input  logic                out_tready,
  output spq_pkg::cmd_t       cmd
);

  spq_pkg::ctl_state_t state_r, state_nxt;
  logic                accept;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command outputs. A new item is taken whenever the result
  // register is free or is being emptied in this cycle.
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    state_nxt  = state_r;
    unique case (state_r)
      spq_pkg::CTL_IDLE: begin
        in_tready = 1'b1;
      end
      spq_pkg::CTL_HOLD: begin
        in_tready  = out_tready;
        out_tvalid = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
    accept = in_tvalid && in_tready;
    if (accept) begin
      state_nxt = spq_pkg::CTL_HOLD;
    end else if (state_r == spq_pkg::CTL_HOLD && out_tready) begin
      state_nxt = spq_pkg::CTL_IDLE;
    end
    cmd.exec = accept;
    cmd.op   = in_op;
  end

endmodule

>>> rtl/spq_datapath.sv
// Record row, occupancy counter and result register of the priority queue.
module spq_datapath #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spq_pkg::cmd_t                cmd,
  input  logic [spq_pkg::CODE_W-1:0]   in_code,
  input  logic [spq_pkg::PRI_W-1:0]    in_pri,
  input  logic [spq_pkg::PAY_W-1:0]    in_pay,
  output spq_pkg::status_t             res_status,
  output logic [spq_pkg::CODE_W-1:0]   res_code,
  output logic [spq_pkg::PRI_W-1:0]    res_pri,
  output logic [spq_pkg::PAY_W-1:0]    res_pay,
  output logic [spq_pkg::OCC_W-1:0]    res_occ
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]                count_r, count_nxt;
  logic [spq_pkg::CODE_W-1:0]   code_r [DEPTH];
  logic [spq_pkg::PRI_W-1:0]    pri_r  [DEPTH];
  logic [spq_pkg::PAY_W-1:0]    pay_r  [DEPTH];
  logic [DEPTH-1:0]             vld, ge, prev_vld, prev_ge;
  spq_pkg::sel_t                sel [DEPTH];
  logic                         full, empty, do_enq, do_deq;
  logic [CW+spq_pkg::OCC_W-1:0] count_ext;

  spq_pkg::status_t             status_r;
  logic [spq_pkg::CODE_W-1:0]   rcode_r;
  logic [spq_pkg::PRI_W-1:0]    rpri_r;
  logic [spq_pkg::PAY_W-1:0]    rpay_r;
  logic [spq_pkg::OCC_W-1:0]    rocc_r;

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign do_enq = cmd.exec && (cmd.op == spq_pkg::OP_ENQ) && !full;
  assign do_deq = cmd.exec && (cmd.op == spq_pkg::OP_DEQ) && !empty;

  // Each slot compares its own priority against the new one in parallel.
  // Slots below the count hold valid records in service order.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      vld[k] = (CW'(k) < count_r);
      ge[k]  = (pri_r[k] >= in_pri);
    end
    prev_vld = {vld[DEPTH-2:0], 1'b1};
    prev_ge  = {ge[DEPTH-2:0], 1'b1};
  end

  // Slot update selects. On an enqueue the first slot that is not a valid
  // record of greater or equal priority takes the new record, and the valid
  // slots after it shift up by one. A dequeue shifts all but the last down.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      sel[k] = spq_pkg::SEL_HOLD;
      if (do_enq && !(vld[k] && ge[k])) begin
        if (prev_vld[k] && prev_ge[k]) begin
          sel[k] = spq_pkg::SEL_NEW;
        end else if (prev_vld[k]) begin
          sel[k] = spq_pkg::SEL_PREV;
        end
      end else if (do_deq && k < DEPTH - 1) begin
        sel[k] = spq_pkg::SEL_NEXT;
      end
    end
  end

  // Record row: each slot reads only itself and its two neighbors.
  for (genvar k = 0; k < DEPTH; k++) begin : g_slot
    localparam int PRV = (k == 0) ? 0 : k - 1;
    localparam int NXT = (k == DEPTH - 1) ? k : k + 1;
    always_ff @(posedge clk) begin
      case (sel[k])
        spq_pkg::SEL_NEW: begin
          code_r[k] <= in_code;
          pri_r[k]  <= in_pri;
          pay_r[k]  <= in_pay;
        end
        spq_pkg::SEL_PREV: begin
          code_r[k] <= code_r[PRV];
          pri_r[k]  <= pri_r[PRV];
          pay_r[k]  <= pay_r[PRV];
        end
        spq_pkg::SEL_NEXT: begin
          code_r[k] <= code_r[NXT];
          pri_r[k]  <= pri_r[NXT];
          pay_r[k]  <= pay_r[NXT];
        end
        default: begin
          code_r[k] <= code_r[k];
          pri_r[k]  <= pri_r[k];
          pay_r[k]  <= pay_r[k];
        end
      endcase
    end
  end

  // Occupancy counter.
  always_comb begin
    count_nxt = count_r;
    if (do_enq) begin
      count_nxt = count_r + CW'(1);
    end else if (do_deq) begin
      count_nxt = count_r - CW'(1);
    end
    count_ext = {{spq_pkg::OCC_W{1'b0}}, count_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result register, loaded once per accepted item.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rocc_r  <= count_ext[spq_pkg::OCC_W-1:0];
      rcode_r <= '0;
      rpri_r  <= '0;
      rpay_r  <= '0;
      if (cmd.op == spq_pkg::OP_ENQ) begin
        status_r <= full ? spq_pkg::STAT_FULL : spq_pkg::STAT_DONE;
      end else if (empty) begin
        status_r <= spq_pkg::STAT_EMPTY;
      end else begin
        status_r <= spq_pkg::STAT_DONE;
        rcode_r  <= code_r[0];
        rpri_r   <= pri_r[0];
        rpay_r   <= pay_r[0];
      end
    end
  end

  assign res_status = status_r;
  assign res_code   = rcode_r;
  assign res_pri    = rpri_r;
  assign res_pay    = rpay_r;
  assign res_occ    = rocc_r;

endmodule

>>> rtl/stable_priority_queue.sv
// Latency: a result item is valid the cycle after its input item is accepted.
// Throughput: one item per cycle while out_tready is high; the row shifts and
// inserts at once, and a new item is taken while the result register drains.
// Reset: synchronous active-low; clears the record count and the result
// register's valid state. Record slot contents are not cleared.
module stable_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] record_code, [23:16] priority_req, [87:24] payload_bits
  input  logic [87:0] in_tdata,
  // [0] operation
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] removed_code, [23:16] removed_priority, [87:24] removed_payload,
  // [92:88] occupancy, [95:93] zero
  output logic [95:0] out_tdata,
  // [1:0] status
  output logic [1:0]  out_tuser
);

  spq_pkg::cmd_t                 cmd;
  spq_pkg::status_t              res_status;
  logic [spq_pkg::CODE_W-1:0]    res_code;
  logic [spq_pkg::PRI_W-1:0]     res_pri;
  logic [spq_pkg::PAY_W-1:0]     res_pay;
  logic [spq_pkg::OCC_W-1:0]     res_occ;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (spq_pkg::op_t'(in_tuser[0])),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_code    (in_tdata[15:0]),
    .in_pri     (in_tdata[23:16]),
    .in_pay     (in_tdata[87:24]),
    .res_status (res_status),
    .res_code   (res_code),
    .res_pri    (res_pri),
    .res_pay    (res_pay),
    .res_occ    (res_occ)
  );

  // Pack the result item.
  assign out_tdata = {3'b000, res_occ, res_pay, res_pri, res_code};
  assign out_tuser = res_status;

`ifndef NO_ASSERTIONS
  // An accepted item always shows a result in the next cycle.
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("no result after an accepted item");

  // A dropped enqueue only happens when the store is full.
  a_full_occ : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == spq_pkg::STAT_FULL) |-> (res_occ == 5'(DEPTH)))
    else $error("full status with occupancy below depth");

  // An empty dequeue returns zero fields and zero occupancy.
  a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == spq_pkg::STAT_EMPTY) |->
      (res_occ == '0 && res_code == '0 && res_pri == '0 && res_pay == '0))
    else $error("empty status with nonzero fields");
`endif

endmodule
